// ===== rtl/vn_pkg.sv =====
// shared types and constants for the vector3_normalize block
// no dependencies
`default_nettype none
package vn_pkg;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   typedef struct packed {
      logic signed [31:0] comp_x;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic [31:0]        vec_length;
      logic               degenerate;
   } rsp_type;

   // component magnitudes and signs carried beside the root pipeline
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } side_type;
endpackage
`default_nettype wire

// ===== rtl/vn_sqrt_pipe.sv =====
// pipelined floored square root of a 64-bit value, one result bit per stage
// depends on vn_pkg
`default_nettype none
module vn_sqrt_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [63:0]       in_sum,
   input  wire vn_pkg::side_type  in_side,
   output logic                   out_valid,
   output logic [31:0]            out_root,
   output vn_pkg::side_type       out_side
);
   import vn_pkg::*;

   logic             valid_ff [0:SQRT_STEPS];
   logic [63:0]      val_ff   [0:SQRT_STEPS];
   logic [33:0]      rem_ff   [0:SQRT_STEPS];
   logic [31:0]      root_ff  [0:SQRT_STEPS];
   side_type         side_ff  [0:SQRT_STEPS];

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         val_ff[0]  <= in_sum;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage
   for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
      logic [35:0] temp;
      logic [35:0] trial;
      logic        ge;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         temp    = {rem_ff[k-1], val_ff[k-1][63:62]};
         trial   = {2'b00, root_ff[k-1], 2'b01};
         ge      = (temp >= trial);
         rem_in  = ge ? 34'(temp - trial) : temp[33:0];
         root_in = {root_ff[k-1][30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            val_ff[k]  <= {val_ff[k-1][61:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];
   assign out_side  = side_ff[SQRT_STEPS];
endmodule
`default_nettype wire

// ===== rtl/vn_div_pipe.sv =====
// three-lane pipelined restoring divider, one quotient bit per stage,
// with saturation, sign and degenerate handling in the output register
// depends on vn_pkg
`default_nettype none
module vn_div_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire vn_pkg::side_type  in_side,
   input  wire logic [31:0]       in_len,
   input  wire logic              in_degenerate,
   output logic                   out_valid,
   output vn_pkg::rsp_type        out_data
);
   import vn_pkg::*;

   logic                   valid_ff [0:DIV_STEPS];
   logic [2:0][31:0]       rem_ff   [0:DIV_STEPS];
   logic [2:0][30:0]       quo_ff   [0:DIV_STEPS];
   logic [2:0]             ovf_ff   [0:DIV_STEPS];
   logic [2:0]             lsb_ff   [0:DIV_STEPS];
   logic [2:0]             neg_ff   [0:DIV_STEPS];
   logic [31:0]            len_ff   [0:DIV_STEPS];
   logic                   deg_ff   [0:DIV_STEPS];
   logic                   out_valid_ff;
   rsp_type                out_ff;
   rsp_type                out_in;

   // load stage: dividend is magnitude shifted up 30, high part seeds remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= {1'b0, in_side.mag[i][31:1]};
            ovf_ff[0][i] <= ({1'b0, in_side.mag[i][31:1]} >= in_len);
            lsb_ff[0][i] <= in_side.mag[i][0];
            quo_ff[0][i] <= '0;
         end
         neg_ff[0] <= in_side.neg;
         len_ff[0] <= in_len;
         deg_ff[0] <= in_degenerate;
      end
   end

   // one quotient bit per stage in each lane
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [2:0][31:0] rem_in;
      logic [2:0][30:0] quo_in;

      always_comb begin
         logic [32:0] t;
         logic        ge;
         for (int i = 0; i < 3; i++) begin
            t  = {rem_ff[k-1][i], (k == 1) ? lsb_ff[k-1][i] : 1'b0};
            ge = (t >= {1'b0, len_ff[k-1]});
            rem_in[i] = ge ? 32'(t - {1'b0, len_ff[k-1]}) : t[31:0];
            quo_in[i] = {quo_ff[k-1][i][29:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_ff[k-1];
            lsb_ff[k] <= lsb_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            len_ff[k] <= len_ff[k-1];
            deg_ff[k] <= deg_ff[k-1];
         end
      end
   end

   // saturate at one, apply sign, force zero vector when degenerate
   always_comb begin
      logic [2:0][31:0] unit;
      logic [31:0]      q;
      for (int i = 0; i < 3; i++) begin
         q = {1'b0, quo_ff[DIV_STEPS][i]};
         if (ovf_ff[DIV_STEPS][i] || (q > ONE_Q30)) begin
            q = ONE_Q30;
         end
         if (deg_ff[DIV_STEPS]) begin
            unit[i] = '0;
         end else if (neg_ff[DIV_STEPS][i]) begin
            unit[i] = 32'(-q);
         end else begin
            unit[i] = q;
         end
      end
      out_in.unit_x     = unit[0];
      out_in.unit_y     = unit[1];
      out_in.unit_z     = unit[2];
      out_in.vec_length = len_ff[DIV_STEPS];
      out_in.degenerate = deg_ff[DIV_STEPS];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
endmodule
`default_nettype wire

// ===== rtl/vector3_normalize.sv =====
// Normalizes one signed Q16.16 vector per clock into a signed Q1.30 unit
// vector plus its Q16.16 length. The block is a fixed pipeline of 69
// register stages: magnitude, squaring, sum, a load stage and 32 square-root
// stages (one root bit each), a compare/load stage, 31 divider stages (one
// quotient bit each, three lanes), and the output register; a new transaction
// may enter every cycle. The whole pipeline holds while a result waits under
// rsp_stall; req_stall follows rsp_stall in that case only. Lengths below
// min_length (csr, reset 1) or equal to zero give the zero vector with
// degenerate set. Write min_length only while the pipeline is empty.
// depends on vn_pkg, vn_sqrt_pipe, vn_div_pipe
`default_nettype none
module vector3_normalize (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire vn_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output vn_pkg::rsp_type       rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [16:0]      csr_write_data
);
   import vn_pkg::*;

   logic             en;
   logic [16:0]      min_len_ff;
   logic             v1_ff, v2_ff, v3_ff;
   side_type         side1_ff, side2_ff, side3_ff;
   logic [2:0][63:0] sq_ff;
   logic [63:0]      sum_ff;
   side_type         side_in;
   logic             sq_valid;
   logic [31:0]      root;
   side_type         root_side;
   logic             degenerate;
   logic             out_valid;
   rsp_type          out_data;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = rsp_valid && rsp_stall;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= 17'd1;
      end else if (csr_write_enable) begin
         min_len_ff <= csr_write_data;
      end
   end

   // component magnitudes
   always_comb begin
      side_in.neg[0] = req_data.comp_x[31];
      side_in.neg[1] = req_data.comp_y[31];
      side_in.neg[2] = req_data.comp_z[31];
      side_in.mag[0] = req_data.comp_x[31] ? 32'(-req_data.comp_x) : req_data.comp_x;
      side_in.mag[1] = req_data.comp_y[31] ? 32'(-req_data.comp_y) : req_data.comp_y;
      side_in.mag[2] = req_data.comp_z[31] ? 32'(-req_data.comp_z) : req_data.comp_z;
   end

   // magnitude, square and sum stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         side1_ff <= side_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= {32'd0, side1_ff.mag[i]} * {32'd0, side1_ff.mag[i]};
         end
         side2_ff <= side1_ff;
         sum_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         side3_ff <= side2_ff;
      end
   end

   vn_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_sum    (sum_ff),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_side  (root_side)
   );

   // minimum length check
   assign degenerate = (root < {15'd0, min_len_ff}) || (root == 32'd0);

   vn_div_pipe u_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (sq_valid),
      .in_side       (root_side),
      .in_len        (root),
      .in_degenerate (degenerate),
      .out_valid     (out_valid),
      .out_data      (out_data)
   );

   assign rsp_valid = out_valid;
   assign rsp_data  = out_data;

   // degenerate results carry the zero vector
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
         (rsp_data.unit_x == 0 && rsp_data.unit_y == 0 && rsp_data.unit_z == 0))
      else $error("degenerate result with nonzero unit vector");

   // unit magnitudes never exceed one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.unit_x <= $signed(ONE_Q30) && rsp_data.unit_x >= -$signed(ONE_Q30) &&
          rsp_data.unit_y <= $signed(ONE_Q30) && rsp_data.unit_y >= -$signed(ONE_Q30) &&
          rsp_data.unit_z <= $signed(ONE_Q30) && rsp_data.unit_z >= -$signed(ONE_Q30)))
      else $error("unit component beyond one");

   // input is held back only by a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule
`default_nettype wire
